// ----- design/xcr_pkg.sv -----
// Package: shared widths, constants, verdict codes and digit/verdict helper functions.
`default_nettype none

package xcr_pkg;

    localparam int unsigned ByteW  = 8;
    localparam int unsigned CpW    = 21;
    // Wide enough for CP_MAX * 16 + 15 before saturation
    localparam int unsigned ProdW  = CpW + 4;

    localparam logic [CpW-1:0] CP_MAX     = 21'h10FFFF;
    localparam logic [CpW-1:0] SURR_MASK  = 21'h0007FF;
    localparam logic [CpW-1:0] SURR_TOP   = 21'h00DFFF;
    localparam logic [CpW-1:0] NONCHAR    = 21'h00FFFF;
    localparam logic [CpW-1:0] CTRL_LIMIT = 21'h000020;
    localparam logic [CpW-1:0] CP_TAB     = 21'h000009;
    localparam logic [CpW-1:0] CP_LF      = 21'h00000A;
    localparam logic [CpW-1:0] CP_CR      = 21'h00000D;

    typedef enum logic [1:0] {
        VERDICT_VALID   = 2'd0,
        VERDICT_INVALID = 2'd1,
        VERDICT_CTRL    = 2'd2
    } verdict_t;

    typedef struct packed {
        logic       ok;
        logic [3:0] value;
    } digit_t;

    // Decode one byte as a digit of the selected base
    function automatic digit_t digit_of(input logic [ByteW-1:0] b, input logic hex);
        digit_t d;
        d.ok    = 1'b0;
        d.value = 4'd0;
        case (b) inside
            [8'h30:8'h39]:
            begin
                d.ok    = 1'b1;
                d.value = 4'(b - 8'h30);
            end
            [8'h61:8'h66]:
            begin
                d.ok    = hex;
                d.value = 4'(b - 8'h61 + 8'd10);
            end
            [8'h41:8'h46]:
            begin
                d.ok    = hex;
                d.value = 4'(b - 8'h41 + 8'd10);
            end
            default:
            begin
                d.ok    = 1'b0;
                d.value = 4'd0;
            end
        endcase
        return d;
    endfunction

    // Classify a finished reference value
    function automatic verdict_t judge(input logic [CpW-1:0] v, input logic ovf);
        verdict_t r;
        if (ovf || (v == '0) || ((v | SURR_MASK) == SURR_TOP)
            || ((v | CpW'(1)) == NONCHAR))
        begin
            r = VERDICT_INVALID;
        end
        else if ((v < CTRL_LIMIT) && (v != CP_TAB) && (v != CP_LF) && (v != CP_CR))
        begin
            r = VERDICT_CTRL;
        end
        else
        begin
            r = VERDICT_VALID;
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// ----- design/xcr_in_if.sv -----
// Interface: input byte channel with valid/ready handshake.
`default_nettype none

interface xcr_in_if;
    logic                        valid;
    logic                        ready;
    logic [xcr_pkg::ByteW-1:0]   char_byte;
    logic                        start_req;
    logic                        hex_mode;

    modport source (output valid, output char_byte, output start_req, output hex_mode,
                    input ready);
    modport sink   (input valid, input char_byte, input start_req, input hex_mode,
                    output ready);
endinterface

`default_nettype wire

// ----- design/xcr_out_if.sv -----
// Interface: result channel with valid/ready handshake.
`default_nettype none

interface xcr_out_if;
    logic                        valid;
    logic                        ready;
    logic [1:0]                  verdict;
    logic [xcr_pkg::CpW-1:0]     code_point;
    logic                        overflowed;

    modport source (output valid, output verdict, output code_point, output overflowed,
                    input ready);
    modport sink   (input valid, input verdict, input code_point, input overflowed,
                    output ready);
endinterface

`default_nettype wire

// ----- design/xml_char_reference_checker_core.sv -----
// Top: XML numeric character reference checker, one byte per cycle unless stalled.
`default_nettype none

// Takes the bytes after "&#" or "&#x" one per transfer; start_req opens a new
// reference (abandoning any open one) and latches hex_mode as the base. Each digit
// updates a saturating accumulator; the first non-digit byte closes the reference
// and yields one result: verdict, code point (0x10FFFF when overflowed) and the
// sticky overflow flag. Bytes seen while no reference is open are dropped. The
// block takes one byte every cycle unless a result waits: a byte goes into an
// input register, the multiply-by-ten-or-sixteen add and verdict logic then fill
// the result register, and a result is offered once the closing byte has gone
// through both. The state update stalls only while the result register holds a
// result not yet taken; the input register then takes one more byte and holds it.
module xml_char_reference_checker_core (
    input  wire        clk,
    input  wire        rst_n,
    xcr_in_if.sink     char_in,
    xcr_out_if.source  result_out
);

    // Input register stage
    logic                        in_valid_reg;
    logic [xcr_pkg::ByteW-1:0]   in_byte_reg;
    logic                        in_start_reg;
    logic                        in_hex_reg;

    // Reference state
    logic [xcr_pkg::CpW-1:0]     acc_reg;
    logic [xcr_pkg::CpW-1:0]     acc_next;
    logic                        ovf_reg;
    logic                        ovf_next;
    logic                        active_reg;
    logic                        active_next;
    logic                        hex_reg;
    logic                        hex_next;

    // Result register stage
    logic                        out_valid_reg;
    logic                        out_valid_next;
    xcr_pkg::verdict_t           verdict_reg;
    logic [xcr_pkg::CpW-1:0]     code_point_reg;
    logic                        overflowed_reg;

    logic                        advance;
    logic                        base_hex;
    logic                        open_now;
    logic [xcr_pkg::CpW-1:0]     acc_cur;
    logic                        ovf_cur;
    xcr_pkg::digit_t             dig;
    logic [xcr_pkg::ProdW-1:0]   acc_wide;
    logic [xcr_pkg::ProdW-1:0]   prod;
    logic [xcr_pkg::ProdW-1:0]   sum;
    logic                        sat;
    logic                        closing;

    // State and result stages move unless a result is waiting on the output
    assign advance      = !out_valid_reg || result_out.ready;
    assign char_in.ready = !in_valid_reg || advance;

    // Capture an incoming byte
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (char_in.ready)
        begin
            in_valid_reg <= char_in.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (char_in.ready && char_in.valid)
        begin
            in_byte_reg  <= char_in.char_byte;
            in_start_reg <= char_in.start_req;
            in_hex_reg   <= char_in.hex_mode;
        end
    end

    // Resolve the effective state after an optional restart
    assign base_hex = in_start_reg ? in_hex_reg : hex_reg;
    assign open_now = in_start_reg || active_reg;
    assign acc_cur  = in_start_reg ? '0 : acc_reg;
    assign ovf_cur  = in_start_reg ? 1'b0 : ovf_reg;
    assign dig      = xcr_pkg::digit_of(in_byte_reg, base_hex);

    // Accumulate: times 16 by shift, times 10 as 8x + 2x
    assign acc_wide = xcr_pkg::ProdW'(acc_cur);
    assign prod     = base_hex ? (acc_wide << 4) : ((acc_wide << 3) + (acc_wide << 1));
    assign sum      = prod + xcr_pkg::ProdW'(dig.value);
    assign sat      = sum > xcr_pkg::ProdW'(xcr_pkg::CP_MAX);
    assign closing  = in_valid_reg && open_now && !dig.ok;

    always_comb
    begin
        acc_next       = acc_reg;
        ovf_next       = ovf_reg;
        active_next    = active_reg;
        hex_next       = hex_reg;
        out_valid_next = out_valid_reg && !result_out.ready;
        if (advance)
        begin
            out_valid_next = closing;
            if (in_valid_reg && open_now)
            begin
                hex_next = base_hex;
                if (dig.ok)
                begin
                    acc_next    = sat ? xcr_pkg::CP_MAX : sum[xcr_pkg::CpW-1:0];
                    ovf_next    = ovf_cur || sat;
                    active_next = 1'b1;
                end
                else
                begin
                    acc_next    = acc_cur;
                    ovf_next    = ovf_cur;
                    active_next = 1'b0;
                end
            end
        end
    end

    // Update reference state and result valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg       <= '0;
            ovf_reg       <= 1'b0;
            active_reg    <= 1'b0;
            hex_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            acc_reg       <= acc_next;
            ovf_reg       <= ovf_next;
            active_reg    <= active_next;
            hex_reg       <= hex_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Load the result payload on a closing byte
    always_ff @(posedge clk)
    begin
        if (advance && closing)
        begin
            verdict_reg    <= xcr_pkg::judge(acc_cur, ovf_cur);
            code_point_reg <= acc_cur;
            overflowed_reg <= ovf_cur;
        end
    end

    assign result_out.valid      = out_valid_reg;
    assign result_out.verdict    = verdict_reg;
    assign result_out.code_point = code_point_reg;
    assign result_out.overflowed = overflowed_reg;

`ifndef SYNTHESIS
    // Overflow always leaves the accumulator saturated
    a_ovf_saturates: assert property (@(posedge clk) disable iff (!rst_n)
        ovf_reg |-> (acc_reg == xcr_pkg::CP_MAX))
        else $error("overflow flag set without saturated accumulator");

    // An overflowed result is saturated and judged invalid
    a_ovf_result: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && overflowed_reg) |->
            ((code_point_reg == xcr_pkg::CP_MAX)
             && (verdict_reg == xcr_pkg::VERDICT_INVALID)))
        else $error("overflowed result not saturated or not invalid");

    // A start byte that is a digit opens a reference holding that digit
    a_start_digit: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && in_valid_reg && in_start_reg && dig.ok) |=>
            (active_reg && (acc_reg == xcr_pkg::CpW'($past(dig.value)))))
        else $error("start digit did not open a reference");
`endif

endmodule

`default_nettype wire
